// File: rtl/particle_box_and_proximity_check_macros.svh
// assertion macros used by the particle proximity check sequencer
`ifndef PARTICLE_BOX_AND_PROXIMITY_CHECK_MACROS_SVH
`define PARTICLE_BOX_AND_PROXIMITY_CHECK_MACROS_SVH

// same-cycle implication, checked outside reset
`define PBPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pbpc_pkg.sv
// types and constants of the particle proximity check
package pbpc_pkg;

  localparam int COORD_W    = 16;
  localparam int POS_W      = 3 * COORD_W;
  localparam int HALF_BOX_W = 15;
  localparam int DSQ_W      = 34;
  localparam int PIDX_W     = 7;
  localparam int PART_W     = 6;
  localparam int CCNT_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DSQ_W;

  localparam logic [HALF_BOX_W-1:0] HALF_BOX_RST  = 15'd1920;
  localparam logic [DSQ_W-1:0]      RADIUS_SQ_RST = 34'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_BOX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ = 1'd1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_PAIR    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQ,
    ST_ADD,
    ST_TEST,
    ST_SUM,
    ST_FULL
  } pbpc_state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD
  } acc_op_t;

  // control from the sequencer to the square-accumulate unit
  typedef struct packed {
    logic    sq_en;
    axis_t   axis;
    acc_op_t acc_op;
  } sqacc_ctl_t;

endpackage

// File: rtl/pbpc_ram.sv
// generic single-write, registered-read ram
module pbpc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/pbpc_sqacc.sv
// shared unit: per-axis difference, square and sum of squares
module pbpc_sqacc (
  input  logic                            clk,
  input  logic [pbpc_pkg::POS_W-1:0]      cur_pos,
  input  logic [pbpc_pkg::POS_W-1:0]      store_pos,
  input  pbpc_pkg::sqacc_ctl_t            ctl,
  output logic [pbpc_pkg::DSQ_W-1:0]      acc
);

  import pbpc_pkg::*;

  logic signed [COORD_W-1:0] a_sel;
  logic signed [COORD_W-1:0] b_sel;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          diff_abs;
  logic [COORD_W-1:0]        mag;
  logic [2*COORD_W-1:0]      prod_r;
  logic [DSQ_W-1:0]          acc_r;

  always_comb begin
    case (ctl.axis)
      AXIS_X: begin
        a_sel = cur_pos[COORD_W-1:0];
        b_sel = store_pos[COORD_W-1:0];
      end
      AXIS_Y: begin
        a_sel = cur_pos[2*COORD_W-1:COORD_W];
        b_sel = store_pos[2*COORD_W-1:COORD_W];
      end
      AXIS_Z: begin
        a_sel = cur_pos[3*COORD_W-1:2*COORD_W];
        b_sel = store_pos[3*COORD_W-1:2*COORD_W];
      end
      default: begin
        a_sel = cur_pos[COORD_W-1:0];
        b_sel = store_pos[COORD_W-1:0];
      end
    endcase
  end

  // difference needs 17 bits, its magnitude fits in 16
  assign diff     = {a_sel[COORD_W-1], a_sel} - {b_sel[COORD_W-1], b_sel};
  assign diff_abs = diff[COORD_W] ? -diff : diff;
  assign mag      = diff_abs[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.sq_en) begin
      prod_r <= mag * mag;
    end
    case (ctl.acc_op)
      ACC_CLEAR: acc_r <= '0;
      ACC_ADD:   acc_r <= acc_r + DSQ_W'(prod_r);
      default:   acc_r <= acc_r;
    endcase
  end

  assign acc = acc_r;

endmodule

// File: rtl/pbpc_seq.sv
// sequencer: handshakes, partner loop, store bookkeeping, result register
`include "particle_box_and_proximity_check_macros.svh"

module pbpc_seq #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pbpc_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [pbpc_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [pbpc_pkg::COORD_W-1:0]  in_pos_z,
  input  logic                                 in_first,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_kind,
  output logic [pbpc_pkg::PIDX_W-1:0]          out_particle_index,
  output logic [pbpc_pkg::PART_W-1:0]          out_partner_index,
  output logic [2:0]                           out_outside_mask,
  output logic [pbpc_pkg::CCNT_W-1:0]          out_close_count,
  output logic [pbpc_pkg::DSQ_W-1:0]           out_dist_sq,
  output logic                                 out_last,
  input  logic [pbpc_pkg::HALF_BOX_W-1:0]      half_box,
  input  logic [pbpc_pkg::DSQ_W-1:0]           radius_sq,
  output logic                                 ram_we,
  output logic [$clog2(MAX_PARTICLES)-1:0]     ram_waddr,
  output logic [pbpc_pkg::POS_W-1:0]           ram_wdata,
  output logic                                 ram_re,
  output logic [$clog2(MAX_PARTICLES)-1:0]     ram_raddr,
  output logic [pbpc_pkg::POS_W-1:0]           cur_pos,
  output pbpc_pkg::sqacc_ctl_t                 sq_ctl,
  input  logic [pbpc_pkg::DSQ_W-1:0]           acc
);

  import pbpc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_PARTICLES);
  localparam logic [PIDX_W-1:0] FULL_IDX = PIDX_W'(MAX_PARTICLES);

  function automatic logic [COORD_W-1:0] coord_mag(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? -v : v;
  endfunction

  pbpc_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   close_r;
  axis_t              axis_r;
  logic [POS_W-1:0]   pos_r;
  logic [2:0]         mask_r;

  logic               out_valid_r;
  logic               out_kind_r;
  logic [PIDX_W-1:0]  out_pidx_r;
  logic [PART_W-1:0]  out_part_r;
  logic [2:0]         out_mask_r;
  logic [CCNT_W-1:0]  out_ccnt_r;
  logic [DSQ_W-1:0]   out_dsq_r;
  logic               out_last_r;

  logic               in_accept;
  logic [CNT_W-1:0]   eff_cnt;
  logic [2:0]         in_mask;
  logic               out_free;
  logic               is_close;
  logic               idx_last;
  logic [31:0]        cnt_w32;
  logic [31:0]        idx_w32;
  logic [31:0]        close_w32;

  logic               pair_load;
  logic               step;
  logic               sum_load;
  logic               full_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign eff_cnt   = in_first ? '0 : cnt_r;
  assign out_free  = !out_valid_r || out_ready;
  assign is_close  = (acc <= radius_sq);
  assign idx_last  = ((idx_r + CNT_W'(1)) == cnt_r);
  assign cnt_w32   = 32'(cnt_r);
  assign idx_w32   = 32'(idx_r);
  assign close_w32 = 32'(close_r);

  assign in_mask[0] = coord_mag(in_pos_x) >= {1'b0, half_box};
  assign in_mask[1] = coord_mag(in_pos_y) >= {1'b0, half_box};
  assign in_mask[2] = coord_mag(in_pos_z) >= {1'b0, half_box};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (eff_cnt == MAX_CNT) begin
            state_nxt = ST_FULL;
          end else if (eff_cnt == '0) begin
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: state_nxt = ST_SQ;
      ST_SQ: begin
        if (axis_r == AXIS_Z) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: state_nxt = ST_TEST;
      ST_TEST: begin
        if (!is_close || out_free) begin
          state_nxt = idx_last ? ST_SUM : ST_READ;
        end
      end
      ST_SUM, ST_FULL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    ram_re        = 1'b0;
    sq_ctl.sq_en  = 1'b0;
    sq_ctl.axis   = axis_r;
    sq_ctl.acc_op = ACC_HOLD;
    pair_load     = 1'b0;
    step          = 1'b0;
    sum_load      = 1'b0;
    full_load     = 1'b0;
    case (state_r)
      ST_READ: ram_re = 1'b1;
      ST_SQ: begin
        sq_ctl.sq_en  = 1'b1;
        sq_ctl.acc_op = (axis_r == AXIS_X) ? ACC_CLEAR : ACC_ADD;
      end
      ST_ADD: sq_ctl.acc_op = ACC_ADD;
      ST_TEST: begin
        pair_load = is_close && out_free;
        step      = !is_close || out_free;
      end
      ST_SUM:  sum_load  = out_free;
      ST_FULL: full_load = out_free;
      default: ;
    endcase
  end

  assign ram_we    = sum_load;
  assign ram_waddr = cnt_r[ADDR_W-1:0];
  assign ram_wdata = pos_r;
  assign ram_raddr = idx_r[ADDR_W-1:0];
  assign cur_pos   = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      close_r     <= '0;
      axis_r      <= AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        cnt_r   <= eff_cnt;
        idx_r   <= '0;
        close_r <= '0;
      end else if (sum_load) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (step) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (pair_load) begin
        close_r <= close_r + CNT_W'(1);
      end
      case (state_r)
        ST_READ: axis_r <= AXIS_X;
        ST_SQ: begin
          case (axis_r)
            AXIS_X:  axis_r <= AXIS_Y;
            AXIS_Y:  axis_r <= AXIS_Z;
            default: axis_r <= AXIS_X;
          endcase
        end
        default: axis_r <= axis_r;
      endcase
      if (pair_load || sum_load || full_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pos_r  <= {in_pos_z, in_pos_y, in_pos_x};
      mask_r <= in_mask;
    end
    if (pair_load) begin
      out_kind_r <= KIND_PAIR;
      out_pidx_r <= cnt_w32[PIDX_W-1:0];
      out_part_r <= idx_w32[PART_W-1:0];
      out_mask_r <= '0;
      out_ccnt_r <= '0;
      out_dsq_r  <= acc;
      out_last_r <= 1'b0;
    end else if (sum_load || full_load) begin
      out_kind_r <= KIND_SUMMARY;
      out_pidx_r <= full_load ? FULL_IDX : cnt_w32[PIDX_W-1:0];
      out_part_r <= '0;
      out_mask_r <= mask_r;
      out_ccnt_r <= full_load ? '0 : close_w32[CCNT_W-1:0];
      out_dsq_r  <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_particle_index = out_pidx_r;
  assign out_partner_index  = out_part_r;
  assign out_outside_mask   = out_mask_r;
  assign out_close_count    = out_ccnt_r;
  assign out_dist_sq        = out_dsq_r;
  assign out_last           = out_last_r;

  `PBPC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= MAX_CNT, "stored count beyond store depth")
  `PBPC_ASSERT_NOW(a_idx_range, state_r == ST_READ || state_r == ST_SQ || state_r == ST_ADD || state_r == ST_TEST, idx_r < cnt_r, "partner index not below stored count")
  `PBPC_ASSERT_NEXT(a_full_path, in_accept && !in_first && cnt_r == MAX_CNT, state_r == ST_FULL, "full store not taken to full summary")
  `PBPC_ASSERT_NEXT(a_store_append, state_r == ST_SUM && out_free, state_r == ST_IDLE && cnt_r == $past(cnt_r) + CNT_W'(1), "summary did not append particle")

endmodule

// File: rtl/particle_box_and_proximity_check.sv
// top level of the 3d particle box and proximity check
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready   | in_pos_x, in_pos_y, in_pos_z, in_first
//  out     | output    | out_valid / out_ready | out_kind ... out_dist_sq, out_last
//  cfg     | input     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// an item is accepted, then for each earlier particle in the store the sequencer
// does one store read, a squaring step per axis and a final add on the one shared
// 16x16 multiplier path, and a compare, then it writes one summary
// in_ready is high only while the sequencer is idle; the result register lets
// the next item in while the last summary still waits for out_ready
// a stalled close pair report holds the partner loop until it is taken
// synchronous active-low reset clears control and loads the register reset
// values; the position store is not cleared and needs no clearing pass
module particle_box_and_proximity_check #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pbpc_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [pbpc_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [pbpc_pkg::COORD_W-1:0]  in_pos_z,
  input  logic                                 in_first,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_kind,
  output logic [pbpc_pkg::PIDX_W-1:0]          out_particle_index,
  output logic [pbpc_pkg::PART_W-1:0]          out_partner_index,
  output logic [2:0]                           out_outside_mask,
  output logic [pbpc_pkg::CCNT_W-1:0]          out_close_count,
  output logic [pbpc_pkg::DSQ_W-1:0]           out_dist_sq,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [pbpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbpc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import pbpc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_PARTICLES);

  // configuration registers
  logic [HALF_BOX_W-1:0] half_box_r;
  logic [DSQ_W-1:0]      radius_sq_r;

  // store port between sequencer and ram
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [POS_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [POS_W-1:0]  ram_rdata;

  // shared unit hookup
  logic [POS_W-1:0]  cur_pos;
  sqacc_ctl_t        sq_ctl;
  logic [DSQ_W-1:0]  acc;

  // register writes, only while idle by contract
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_box_r  <= HALF_BOX_RST;
      radius_sq_r <= RADIUS_SQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_BOX:  half_box_r  <= cfg_wdata[HALF_BOX_W-1:0];
        REG_RADIUS_SQ: radius_sq_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // position store, {z, y, x} per entry
  pbpc_ram #(
    .WIDTH (POS_W),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // difference, square and sum of squares, one axis per cycle
  pbpc_sqacc u_sqacc (
    .clk       (clk),
    .cur_pos   (cur_pos),
    .store_pos (ram_rdata),
    .ctl       (sq_ctl),
    .acc       (acc)
  );

  // sequencer with the partner loop and result register
  pbpc_seq #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_first           (in_first),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_particle_index (out_particle_index),
    .out_partner_index  (out_partner_index),
    .out_outside_mask   (out_outside_mask),
    .out_close_count    (out_close_count),
    .out_dist_sq        (out_dist_sq),
    .out_last           (out_last),
    .half_box           (half_box_r),
    .radius_sq          (radius_sq_r),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .cur_pos            (cur_pos),
    .sq_ctl             (sq_ctl),
    .acc                (acc)
  );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the particle box and proximity check
`timescale 1ns / 100ps

module tb_top;
  import pbpc_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam int CYCLE_LIMIT = 4_000_000;
  // settle time at the end, enough for a 63-partner scan
  localparam int END_SETTLE = 400;
  localparam logic [DSQ_W-1:0] RADIUS_SQ_MAX = '1;
  localparam logic [CFG_DATA_W-1:0] HALF_BOX_MAX = CFG_DATA_W'(32767);

  typedef logic signed [COORD_W-1:0] coord_t;

  // one result transaction as the block should present it
  typedef struct {
    logic              kind;
    logic [PIDX_W-1:0] particle_index;
    logic [PART_W-1:0] partner_index;
    logic [2:0]        outside_mask;
    logic [CCNT_W-1:0] close_count;
    logic [DSQ_W-1:0]  dist_sq;
    logic              last;
  } prox_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  coord_t                in_pos_x = '0;
  coord_t                in_pos_y = '0;
  coord_t                in_pos_z = '0;
  logic                  in_first = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_kind;
  logic [PIDX_W-1:0]     out_particle_index;
  logic [PART_W-1:0]     out_partner_index;
  logic [2:0]            out_outside_mask;
  logic [CCNT_W-1:0]     out_close_count;
  logic [DSQ_W-1:0]      out_dist_sq;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state: register copies, the stored snapshot and its fill level
  logic [HALF_BOX_W-1:0] half_box_now = HALF_BOX_RST;
  logic [DSQ_W-1:0]      radius_sq_now = RADIUS_SQ_RST;
  coord_t                snapshot_pos [NUM_SLOTS][3];
  int                    snapshot_fill = 0;

  // reports still owed by the block, oldest first
  prox_report_t pending_reports [$];

  int error_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit source_steady = 1'b0;
  bit sink_steady = 1'b0;

  particle_box_and_proximity_check #(
    .MAX_PARTICLES(NUM_SLOTS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_first           (in_first),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_particle_index (out_particle_index),
    .out_partner_index  (out_partner_index),
    .out_outside_mask   (out_outside_mask),
    .out_close_count    (out_close_count),
    .out_dist_sq        (out_dist_sq),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(7, 29) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void push_report(logic kind, int pidx, int partner, logic [2:0] mask,
                                      int count, longint unsigned dsq, logic last_flag);
    prox_report_t r;
    r.kind           = kind;
    r.particle_index = PIDX_W'(pidx);
    r.partner_index  = PART_W'(partner);
    r.outside_mask   = mask;
    r.close_count    = CCNT_W'(count);
    r.dist_sq        = DSQ_W'(dsq);
    r.last           = last_flag;
    pending_reports.push_back(r);
  endfunction

  // works out every report one accepted particle causes, then stores it unless the store is full
  function automatic void predict_particle(coord_t px, coord_t py, coord_t pz, bit first_flag);
    coord_t          p [3];
    logic [2:0]      mask;
    int              mag;
    int              diff;
    int              n_close;
    longint unsigned dsq;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    mask = '0;
    n_close = 0;
    if (first_flag) snapshot_fill = 0;
    for (int a = 0; a < 3; a++) begin
      mag = (p[a] < 0) ? -int'(p[a]) : int'(p[a]);
      if (mag >= int'(half_box_now)) mask[a] = 1'b1;
    end
    // full store: one summary with the overflow index, no compare, no store
    if (snapshot_fill >= NUM_SLOTS) begin
      push_report(KIND_SUMMARY, NUM_SLOTS, 0, mask, 0, 0, 1'b1);
      return;
    end
    for (int i = 0; i < snapshot_fill; i++) begin
      dsq = 0;
      for (int a = 0; a < 3; a++) begin
        diff = int'(p[a]) - int'(snapshot_pos[i][a]);
        dsq += longint'(diff) * longint'(diff);
      end
      if (dsq <= radius_sq_now) begin
        push_report(KIND_PAIR, snapshot_fill, i, 3'b000, 0, dsq, 1'b0);
        n_close++;
      end
    end
    push_report(KIND_SUMMARY, snapshot_fill, 0, mask, n_close, 0, 1'b1);
    for (int a = 0; a < 3; a++) snapshot_pos[snapshot_fill][a] = p[a];
    snapshot_fill++;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // compare each result transaction with the oldest pending report
  always @(posedge clk) begin : check_results
    prox_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: kind %0d particle_index %0d", out_kind, out_particle_index);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("particle_index", want.particle_index, out_particle_index);
        check_field("partner_index", want.partner_index, out_partner_index);
        check_field("outside_mask", want.outside_mask, out_outside_mask);
        check_field("close_count", want.close_count, out_close_count);
        check_field("dist_sq", want.dist_sq, out_dist_sq);
        check_field("last", want.last, out_last);
      end
    end
  end

  // input side gaps: mostly none, some short, a few long
  function automatic int source_gap();
    int roll;
    if (source_steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // valid stays high across back-to-back transactions, dropped only for a gap
  task automatic send_particle(input coord_t px, input coord_t py, input coord_t pz,
                               input bit first_flag);
    int gap;
    gap = source_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_first <= first_flag;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_ready === 1'b1));
    predict_particle(px, py, pz, first_flag);
  endtask

  // every item ends in a summary, so an empty queue means the block is idle
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HALF_BOX) half_box_now = value[HALF_BOX_W-1:0];
    else if (idx == REG_RADIUS_SQ) radius_sq_now = value;
  endtask

  function automatic logic [DSQ_W-1:0] pick_radius();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return RADIUS_SQ_MAX;
      2: return DSQ_W'($urandom_range(0, 1 << 20));
      3: return DSQ_W'({$urandom, $urandom});
      default: return DSQ_W'(65536 * $urandom_range(1, 64));
    endcase
  endfunction

  // reset register values: box edge at 7.5, radius exactly 1.0
  task automatic test_reset_values_and_bounds();
    send_particle(16'sd0, 16'sd0, 16'sd0, 1'b1);
    // coordinates right on the half box and one step inside
    send_particle(16'sd1920, -16'sd1920, 16'sd1919, 1'b0);
    // duplicate gives a zero-distance pair
    send_particle(16'sd1920, -16'sd1920, 16'sd1919, 1'b0);
    // exactly one radius away counts as close
    send_particle(16'sd2176, -16'sd1920, 16'sd1919, 1'b0);
    // one lsb beyond the radius from the two originals
    send_particle(16'sd2177, -16'sd1920, 16'sd1919, 1'b0);
    // most negative and most positive coordinates
    send_particle(-16'sd32768, 16'sd32767, -16'sd32768, 1'b0);
    // new snapshot in the middle of the stream
    send_particle(16'sd0, 16'sd0, 16'sd0, 1'b1);
  endtask

  task automatic test_half_box_extremes();
    wait_for_idle();
    // zero bound, garbage in the unused upper bits
    write_reg(REG_HALF_BOX, {{(CFG_DATA_W-HALF_BOX_W){1'b1}}, {HALF_BOX_W{1'b0}}});
    send_particle(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_particle(-16'sd1, 16'sd1, 16'sd0, 1'b0);
    wait_for_idle();
    write_reg(REG_HALF_BOX, HALF_BOX_MAX);
    send_particle(16'sd32767, -16'sd32767, -16'sd32768, 1'b1);
    send_particle(16'sd32766, -16'sd32766, 16'sd0, 1'b0);
  endtask

  task automatic test_radius_extremes();
    wait_for_idle();
    // zero radius: only identical positions pair up
    write_reg(REG_RADIUS_SQ, '0);
    send_particle(16'sd100, -16'sd100, 16'sd5, 1'b1);
    send_particle(16'sd100, -16'sd100, 16'sd5, 1'b0);
    send_particle(16'sd101, -16'sd100, 16'sd5, 1'b0);
    wait_for_idle();
    // max radius: opposite corners give the largest squared distance
    write_reg(REG_RADIUS_SQ, RADIUS_SQ_MAX);
    send_particle(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
    send_particle(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_particle(16'sd0, 16'sd0, 16'sd0, 1'b0);
  endtask

  // short snapshots of clustered particles with some scattered ones mixed in
  task automatic test_random_snapshots();
    int     sent;
    int     run_len;
    int     spread;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    bit     first_flag;
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_idle();
      write_reg(REG_HALF_BOX, CFG_DATA_W'({$urandom, $urandom}));
      write_reg(REG_RADIUS_SQ, pick_radius());
      // one phase runs with no idling on either side
      source_steady = (phase == 2);
      sink_steady = (phase == 2);
      sent = 0;
      while (sent < 18) begin
        run_len = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0: spread = 0;
          1: spread = 64;
          2: spread = 256;
          default: spread = 2048;
        endcase
        cx = coord_t'($urandom);
        cy = coord_t'($urandom);
        cz = coord_t'($urandom);
        for (int k = 0; k < run_len; k++) begin
          // mostly a fresh snapshot per run, sometimes a restart mid run
          first_flag = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
          if ($urandom_range(0, 4) == 0) begin
            send_particle(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                          first_flag);
          end else begin
            send_particle(coord_t'(int'(cx) + $urandom_range(0, 2 * spread) - spread),
                          coord_t'(int'(cy) + $urandom_range(0, 2 * spread) - spread),
                          coord_t'(int'(cz) + $urandom_range(0, 2 * spread) - spread),
                          first_flag);
          end
        end
        sent += run_len;
      end
    end
    wait_for_idle();
    source_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  // fill the store with every pair close, then overflow and restart
  task automatic test_store_full();
    wait_for_idle();
    write_reg(REG_RADIUS_SQ, RADIUS_SQ_MAX);
    write_reg(REG_HALF_BOX, CFG_DATA_W'($urandom_range(0, 32767)));
    for (int k = 0; k < NUM_SLOTS + 4; k++) begin
      send_particle(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), k == 0);
    end
    send_particle(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 1'b1);
    send_particle(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 1'b0);
    wait_for_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values_and_bounds();
    test_half_box_extremes();
    test_radius_extremes();
    test_random_snapshots();
    test_store_full();
    wait_for_idle();
    // late extra results would show up as unexpected here
    repeat (END_SETTLE) @(posedge clk);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
